/* hdl/cb_prefix_bit_shift_unit_defines.svh */
// Assertion macros shared by the CB-prefix bit and shift unit.
`ifndef CB_PREFIX_BIT_SHIFT_UNIT_DEFINES_SVH
`define CB_PREFIX_BIT_SHIFT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define CBSU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbsu assertion failed");

// Next-cycle implication, checked on i_clk outside reset.
`define CBSU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbsu assertion failed");

`endif

/* hdl/cbsu_pkg.sv */
// Types, codes and helpers for the CB-prefix bit and shift unit.
`timescale 1ns / 1ps
`default_nettype none

package cbsu_pkg;

    // Opcode groups (bits 7:6)
    localparam logic [1:0] GRP_SHIFT = 2'd0;
    localparam logic [1:0] GRP_BIT   = 2'd1;
    localparam logic [1:0] GRP_RES   = 2'd2;
    localparam logic [1:0] GRP_SET   = 2'd3;

    // Rotate / shift kinds (bits 5:3 in the shift group)
    localparam logic [2:0] SH_RLC  = 3'd0;
    localparam logic [2:0] SH_RRC  = 3'd1;
    localparam logic [2:0] SH_RL   = 3'd2;
    localparam logic [2:0] SH_RR   = 3'd3;
    localparam logic [2:0] SH_SLA  = 3'd4;
    localparam logic [2:0] SH_SRA  = 3'd5;
    localparam logic [2:0] SH_SWAP = 3'd6;
    localparam logic [2:0] SH_SRL  = 3'd7;

    // Operand / load indexes
    localparam logic [2:0] IDX_MEM   = 3'd6;  // memory at HL (execute)
    localparam logic [2:0] IDX_FLAGS = 3'd6;  // flags (load)
    localparam logic [2:0] IDX_A     = 3'd7;

    // Register file slots
    localparam int unsigned NUM_GPR = 7;
    localparam logic [2:0] SLOT_H = 3'd4;
    localparam logic [2:0] SLOT_L = 3'd5;
    localparam logic [2:0] SLOT_A = 3'd6;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    typedef struct packed {
        logic       func;
        logic [7:0] opcode;
        logic [7:0] memory_byte;
        logic [2:0] load_index;
        logic [7:0] load_value;
    } t_req;

    typedef struct packed {
        logic [2:0]  target_index;
        logic [7:0]  result_byte;
        logic        wrote_back;
        logic        memory_write;
        logic [15:0] memory_address;
        logic        flag_zero;
        logic        flag_subtract;
        logic        flag_half;
        logic        flag_carry;
    } t_rsp;

    // Register file update produced by the execute logic
    typedef struct packed {
        logic       gpr_we;
        logic [2:0] gpr_slot;
        logic [7:0] gpr_data;
        t_flags     flags;
    } t_rf_wr;

    // Operand index to register file slot: A sits in the last slot
    function automatic logic [2:0] slot_of(input logic [2:0] idx);
        return (idx == IDX_A) ? SLOT_A : idx;
    endfunction

endpackage

`default_nettype wire

/* hdl/cb_prefix_bit_shift_unit.sv */
// CB-prefix bit and shift unit: request register, execute logic, response register.
// A request passes the request register, then the response register once that is free.
// Throughput: one request per cycle unless the response stalls; the single execute pass
// reads and updates the register file between the two registers, so back-to-back
// requests see fresh state.
// Reset (synchronous, active low) clears both valid bits, the register file and the flags.
`timescale 1ns / 1ps
`default_nettype none
`include "cb_prefix_bit_shift_unit_defines.svh"

module cb_prefix_bit_shift_unit
    import cbsu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output      logic o_req_ready,
    input  wire t_req i_req,
    output      logic o_rsp_valid,
    input  wire logic i_rsp_ready,
    output      t_rsp o_rsp
);

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;
    logic        advance;
    logic [2:0]  rd_slot;
    logic [7:0]  rd_data;
    logic [15:0] hl;
    t_flags      cur_flags;
    t_rf_wr      wr;
    t_rsp        n_out;

    // Request moves to the response register when that register is free
    assign advance     = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || advance;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_req_ready) begin
            r_in_valid <= i_req_valid;
        end
        if (o_req_ready && i_req_valid) begin
            r_in <= i_req;
        end
    end

    cbsu_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_slot (rd_slot),
        .i_wr_en   (advance),
        .i_wr      (wr),
        .o_rd_data (rd_data),
        .o_hl      (hl),
        .o_flags   (cur_flags)
    );

    cbsu_exec u_exec (
        .i_req     (r_in),
        .i_rd_data (rd_data),
        .i_hl      (hl),
        .i_flags   (cur_flags),
        .o_rd_slot (rd_slot),
        .o_wr      (wr),
        .o_rsp     (n_out)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && !i_rsp_ready);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Checks
    `CBSU_ASSERT_IMPL(a_memw_has_wb, o_rsp_valid && o_rsp.memory_write, o_rsp.wrote_back)
    `CBSU_ASSERT_IMPL(a_memw_target, o_rsp_valid && o_rsp.memory_write, o_rsp.target_index == IDX_MEM)
    `CBSU_ASSERT_NEXT(a_accept_fills, i_req_valid && o_req_ready, r_in_valid)
    `CBSU_ASSERT_NEXT(a_advance_fills, advance, r_out_valid)

endmodule

`default_nettype wire

/* hdl/cbsu_regfile.sv */
// Register file B,C,D,E,H,L,A and the Z/N/H/C flags.
`timescale 1ns / 1ps
`default_nettype none

module cbsu_regfile
    import cbsu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [2:0]  i_rd_slot,
    input  wire logic        i_wr_en,
    input  wire t_rf_wr      i_wr,
    output      logic [7:0]  o_rd_data,
    output      logic [15:0] o_hl,
    output      t_flags      o_flags
);

    logic [7:0] r_gpr [NUM_GPR];
    t_flags     r_flags;

    // State update, one request per cycle when i_wr_en is set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_GPR; i++) begin
                r_gpr[i] <= '0;
            end
            r_flags <= '0;
        end else if (i_wr_en) begin
            r_flags <= i_wr.flags;
            if (i_wr.gpr_we) begin
                r_gpr[i_wr.gpr_slot] <= i_wr.gpr_data;
            end
        end
    end

    // Read ports
    assign o_rd_data = r_gpr[i_rd_slot];
    assign o_hl      = {r_gpr[SLOT_H], r_gpr[SLOT_L]};
    assign o_flags   = r_flags;

endmodule

`default_nettype wire

/* hdl/cbsu_exec.sv */
// Execute logic: decode, rotate/shift, BIT/RES/SET, loads and flags.
`timescale 1ns / 1ps
`default_nettype none

module cbsu_exec
    import cbsu_pkg::*;
(
    input  wire t_req        i_req,
    input  wire logic [7:0]  i_rd_data,
    input  wire logic [15:0] i_hl,
    input  wire t_flags      i_flags,
    output      logic [2:0]  o_rd_slot,
    output      t_rf_wr      o_wr,
    output      t_rsp        o_rsp
);

    logic [1:0] grp;
    logic [2:0] sel;
    logic [2:0] zidx;
    logic [7:0] v;
    logic [7:0] sh_res;
    logic       sh_cout;
    logic [7:0] result;
    logic       wrote;
    t_flags     flags;

    assign grp       = i_req.opcode[7:6];
    assign sel       = i_req.opcode[5:3];
    assign zidx      = i_req.opcode[2:0];
    assign o_rd_slot = slot_of(zidx);
    assign v         = (zidx == IDX_MEM) ? i_req.memory_byte : i_rd_data;

    // Rotates and shifts
    always_comb begin
        case (sel)
            SH_RLC:  begin sh_cout = v[7]; sh_res = {v[6:0], v[7]};      end
            SH_RRC:  begin sh_cout = v[0]; sh_res = {v[0], v[7:1]};      end
            SH_RL:   begin sh_cout = v[7]; sh_res = {v[6:0], i_flags.c}; end
            SH_RR:   begin sh_cout = v[0]; sh_res = {i_flags.c, v[7:1]}; end
            SH_SLA:  begin sh_cout = v[7]; sh_res = {v[6:0], 1'b0};      end
            SH_SRA:  begin sh_cout = v[0]; sh_res = {v[7], v[7:1]};      end
            SH_SWAP: begin sh_cout = 1'b0; sh_res = {v[3:0], v[7:4]};    end
            SH_SRL:  begin sh_cout = v[0]; sh_res = {1'b0, v[7:1]};      end
            default: begin sh_cout = 1'b0; sh_res = v;                   end
        endcase
    end

    // Result, write-back and flags
    always_comb begin
        result = v;
        wrote  = 1'b0;
        flags  = i_flags;
        if (i_req.func) begin
            // load: flags take the upper nibble, registers the whole byte
            if (i_req.load_index == IDX_FLAGS) begin
                result = {i_req.load_value[7:4], 4'h0};
                flags  = i_req.load_value[7:4];
            end else begin
                result = i_req.load_value;
            end
        end else begin
            case (grp)
                GRP_SHIFT: begin
                    result  = sh_res;
                    wrote   = 1'b1;
                    flags.z = (sh_res == 8'h00);
                    flags.n = 1'b0;
                    flags.h = 1'b0;
                    flags.c = sh_cout;
                end
                GRP_BIT: begin
                    flags.z = ~v[sel];
                    flags.n = 1'b0;
                    flags.h = 1'b1;
                end
                GRP_RES: begin
                    result = v & ~(8'd1 << sel);
                    wrote  = 1'b1;
                end
                GRP_SET: begin
                    result = v | (8'd1 << sel);
                    wrote  = 1'b1;
                end
                default: begin
                    result = v;
                end
            endcase
        end
    end

    // Register file update
    always_comb begin
        o_wr.flags = flags;
        if (i_req.func) begin
            o_wr.gpr_we   = (i_req.load_index != IDX_FLAGS);
            o_wr.gpr_slot = slot_of(i_req.load_index);
            o_wr.gpr_data = i_req.load_value;
        end else begin
            o_wr.gpr_we   = wrote && (zidx != IDX_MEM);
            o_wr.gpr_slot = o_rd_slot;
            o_wr.gpr_data = result;
        end
    end

    // Response fields
    always_comb begin
        o_rsp.target_index   = i_req.func ? i_req.load_index : zidx;
        o_rsp.result_byte    = result;
        o_rsp.wrote_back     = wrote;
        o_rsp.memory_write   = wrote && (zidx == IDX_MEM);
        o_rsp.memory_address = i_hl;
        o_rsp.flag_zero      = flags.z;
        o_rsp.flag_subtract  = flags.n;
        o_rsp.flag_half      = flags.h;
        o_rsp.flag_carry     = flags.c;
    end

endmodule

`default_nettype wire
